// ===== rtl/rts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB5A3 tile swizzle package
// Beat types, register indexes and the RGBA8 to RGB5A3 conversion.
// ----------------------------------------------------------------------------
package rts_pkg;

  // Configuration port.
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Image size after reset, before clamping to the build limit.
  localparam int unsigned RESET_DIM = 1024;

  // Result field widths.
  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned TEXEL_W = 16;
  localparam int unsigned INDEX_W = 20;

  // One source pixel: A[31:24] B[23:16] G[15:8] R[7:0].
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_word;
  } pix_beat_t;

  // One tiled texel.
  typedef struct packed {
    logic [TEXEL_W-1:0] texel;
    logic [INDEX_W-1:0] tiled_index;
    logic               last_texel;
  } tex_beat_t;

  // Where a pixel lands in the tiled image.
  typedef struct packed {
    logic               keep;
    logic [INDEX_W-1:0] index;
    logic               last;
  } tile_pos_t;

  // Opaque when the top three alpha bits are set: 1-R5-G5-B5.
  // Otherwise 0-A3-R4-G4-B4 from the top bits of each channel.
  function automatic logic [TEXEL_W-1:0] to_rgb5a3(input logic [PIXEL_W-1:0] p);
    logic [TEXEL_W-1:0] t;
    if (p[31:29] == 3'b111) begin
      t = {1'b1, p[7:3], p[15:11], p[23:19]};
    end else begin
      t = {1'b0, p[31:29], p[7:4], p[15:12], p[23:20]};
    end
    return t;
  endfunction

endpackage

// ===== rtl/rts_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one beat of data_t per handshake between a source and a sink.
// ----------------------------------------------------------------------------
interface rts_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rts_tile_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB5A3 tile position mapper
// Maps a raster column and row to the 4x4-tiled texel index and flags
// pixels that fall outside the whole tiles and the final texel.
// ----------------------------------------------------------------------------
module rts_tile_map #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic [$clog2(MAX_DIM)-1:0] col_i,
  input  logic [$clog2(MAX_DIM)-1:0] row_i,
  input  logic [$clog2(MAX_DIM):0]   width_i,
  input  logic [$clog2(MAX_DIM):0]   height_i,
  output rts_pkg::tile_pos_t         pos_o
);
  import rts_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_DIM);
  localparam int unsigned DIM_W  = CNT_W + 1;
  localparam int unsigned PROD_W = 2 * DIM_W;

  logic [DIM_W-1:0]  tiles_wide;
  logic [DIM_W-1:0]  tiles_high;
  logic [DIM_W-1:0]  tile_col;
  logic [DIM_W-1:0]  tile_row;
  logic [PROD_W-1:0] tile_lin;
  logic              keep;
  logic              at_last;

  // Whole tiles across and down; partial tiles are dropped.
  assign tiles_wide = width_i >> 2;
  assign tiles_high = height_i >> 2;
  assign tile_col   = DIM_W'(col_i) >> 2;
  assign tile_row   = DIM_W'(row_i) >> 2;

  // A pixel is kept only inside the whole tiles, which also rules out
  // images narrower or shorter than one tile.
  assign keep = (tile_col < tiles_wide) && (tile_row < tiles_high);

  // Tiles are laid out row-major, 16 texels each, raster order within a tile.
  assign tile_lin = PROD_W'(tile_row) * PROD_W'(tiles_wide) + PROD_W'(tile_col);

  // The last texel is the bottom-right pixel of the last whole tile.
  assign at_last = (col_i[1:0] == 2'b11) && (row_i[1:0] == 2'b11) &&
                   (tile_col == tiles_wide - DIM_W'(1)) &&
                   (tile_row == tiles_high - DIM_W'(1));

  always_comb begin
    pos_o.keep  = keep;
    pos_o.index = INDEX_W'({tile_lin, row_i[1:0], col_i[1:0]});
    pos_o.last  = keep && at_last;
  end

endmodule

// ===== rtl/rgb5a3_tile_swizzle_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB5A3 tile swizzle core
// Converts raster RGBA8 pixels to RGB5A3 texels tagged with their position
// in the 4x4-tiled texture layout.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock and gives each kept pixel as a
// texel beat through two registers: first the input register, where the
// raster position is captured, and then the result register, after the
// conversion and the tile index multiply-add. Throughput is one pixel per
// clock as long as tex_o.ready stays high; pix_i.ready follows tex_o.ready
// combinationally through the two register stages. Pixels right of or below
// the last whole tile are dropped from the input register and never wait.
// Image width and height (clamped to 1..MAX_DIM) must be written while no
// beat is in flight; the raster counters are not reset by a write.
module rgb5a3_tile_swizzle_core #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rts_pkg::CFG_W-1:0]         cfg_data_i,
  rts_stream_if.sink                        pix_i,
  rts_stream_if.source                      tex_o
);
  import rts_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned DIM_W = CNT_W + 1;
  localparam int unsigned CMP_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;
  localparam int unsigned RST_V = (MAX_DIM < RESET_DIM) ? MAX_DIM : RESET_DIM;

  // Configuration, stored already clamped.
  logic [DIM_W-1:0] width_q, width_d;
  logic [DIM_W-1:0] height_q, height_d;
  logic [CMP_W-1:0] cfg_ext;
  logic [DIM_W-1:0] cfg_clamped;

  // Raster position of the next pixel.
  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic             col_wrap;
  logic             row_wrap;

  // Input register stage.
  logic             s1_valid_q, s1_valid_d;
  pix_beat_t        s1_pix_q;
  logic [CNT_W-1:0] s1_col_q;
  logic [CNT_W-1:0] s1_row_q;

  // Result register stage.
  logic             out_valid_q, out_valid_d;
  tex_beat_t        out_q;

  tile_pos_t        pos;
  logic             in_fire;
  logic             out_free;
  logic             s1_adv;
  logic             s1_load_out;

  // Clamp a written size to 1..MAX_DIM.
  always_comb begin
    cfg_ext = CMP_W'(cfg_data_i);
    if (cfg_ext == '0) begin
      cfg_clamped = DIM_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_DIM)) begin
      cfg_clamped = DIM_W'(MAX_DIM);
    end else begin
      cfg_clamped = DIM_W'(cfg_ext);
    end
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_d  = cfg_clamped;
        REG_IMAGE_HEIGHT: height_d = cfg_clamped;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(RST_V);
      height_q <= DIM_W'(RST_V);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Handshake: the input stage moves on when its pixel is dropped or the
  // result register is free or being emptied this cycle.
  assign out_free    = !out_valid_q || tex_o.ready;
  assign s1_adv      = s1_valid_q && (!pos.keep || out_free);
  assign s1_load_out = s1_valid_q && pos.keep && out_free;
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign in_fire     = pix_i.valid && pix_i.ready;

  // Raster counters step on every accepted pixel.
  assign col_wrap = (DIM_W'(col_q) + DIM_W'(1)) >= width_q;
  assign row_wrap = (DIM_W'(row_q) + DIM_W'(1)) >= height_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Input register.
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q <= pix_i.data;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  // Tile position of the registered pixel.
  rts_tile_map #(
    .MAX_DIM (MAX_DIM)
  ) u_tile_map (
    .col_i    (s1_col_q),
    .row_i    (s1_row_q),
    .width_i  (width_q),
    .height_i (height_q),
    .pos_o    (pos)
  );

  // Result register.
  assign out_valid_d = s1_load_out || (out_valid_q && !tex_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load_out) begin
      out_q.texel       <= to_rgb5a3(s1_pix_q.pixel_word);
      out_q.tiled_index <= pos.index;
      out_q.last_texel  <= pos.last;
    end
  end

  assign tex_o.valid = out_valid_q;
  assign tex_o.data  = out_q;

  // A pixel that does not end a row moves the column on by one.
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !col_wrap |=> col_q == $past(col_q) + CNT_W'(1) && row_q == $past(row_q))
    else $error("column counter did not advance");

  // The pixel that ends a row sends the column back to zero.
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && col_wrap |=> col_q == '0)
    else $error("column counter did not wrap");

  // A dropped pixel never fills an empty result register.
  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !pos.keep && !out_valid_q |=> !out_valid_q)
    else $error("dropped pixel produced a texel");

  // A kept pixel waiting on a full result register stays in place.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && pos.keep && !out_free |=>
      s1_valid_q && $stable(s1_pix_q) && $stable(s1_col_q) && $stable(s1_row_q))
    else $error("stalled pixel was lost");

  // The final texel flag only appears on a kept pixel.
  a_last_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && pos.last |-> pos.keep)
    else $error("last texel flagged on dropped pixel");

endmodule
